// ----- hw/rtl/rmsd_pkg.sv -----
// shared types, widths and codes for the running mean and standard deviation engine
package rmsd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GOAL_W     = 16;
    localparam int COUNT_W    = GOAL_W + 1;
    localparam int SUM_W      = SAMPLE_W + COUNT_W;
    localparam int SUMSQ_W    = 2 * SAMPLE_W + COUNT_W;
    localparam int MAG_W      = SAMPLE_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int QUO_W      = 2 * SAMPLE_W;
    localparam int DIVD_W     = QUO_W + COUNT_W - 1;
    localparam int REM_W      = COUNT_W;
    localparam int ROOT_W     = SAMPLE_W;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_START   = 2'd1,
        FUNC_PREEMPT = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        GS_ACTIVE    = 2'd0,
        GS_SUCCEEDED = 2'd1,
        GS_ABORTED   = 2'd2,
        GS_PREEMPTED = 2'd3
    } t_goal_status;

    typedef struct packed {
        t_func                       func;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_in_word;

    typedef struct packed {
        t_goal_status                status;
        logic signed [SAMPLE_W-1:0]  sample_echo;
        logic signed [SAMPLE_W-1:0]  mean;
        logic        [ROOT_W-1:0]    std_dev;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_MEAN,
        ST_LOAD_MSQ,
        ST_DIV_MSQ,
        ST_VAR,
        ST_SQRT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic clear;
        logic take_sample;
        logic square;
        logic accum;
        logic div_load_mean;
        logic div_load_msq;
        logic div_step;
        logic var_load;
        logic sqrt_step;
        logic out_load;
        logic out_preempt;
    } t_dp_cmd;

    typedef struct packed {
        logic finish;
    } t_dp_status;

endpackage

// ----- hw/rtl/rmsd_ctrl.sv -----
// controller state machine: handshakes, armed flag and step sequencing
module rmsd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  rmsd_pkg::t_func      i_func,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output rmsd_pkg::t_dp_cmd    o_cmd,
    input  rmsd_pkg::t_dp_status i_status
);

    rmsd_pkg::t_state r_state, n_state;
    logic                        r_armed, n_armed;
    logic                        r_preempt, n_preempt;
    logic                        r_out_valid, n_out_valid;
    logic [rmsd_pkg::STEP_W-1:0] r_step, n_step;
    logic                        w_accept;
    logic                        w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmsd_pkg::ST_IDLE;
            r_armed     <= 1'b0;
            r_preempt   <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_preempt   <= n_preempt;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    assign o_in_ready  = (r_state == rmsd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_armed     = r_armed;
        n_preempt   = r_preempt;
        n_step      = r_step;
        n_out_valid = (r_out_valid && !i_out_ready);
        o_cmd       = '0;
        unique case (r_state)
            rmsd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_func)
                        rmsd_pkg::FUNC_START: begin
                            o_cmd.clear = 1'b1;
                            n_armed     = 1'b1;
                        end
                        rmsd_pkg::FUNC_PREEMPT: begin
                            if (r_armed) begin
                                n_armed   = 1'b0;
                                n_preempt = 1'b1;
                                n_state   = rmsd_pkg::ST_RESULT;
                            end
                        end
                        rmsd_pkg::FUNC_SAMPLE: begin
                            if (r_armed) begin
                                o_cmd.take_sample = 1'b1;
                                n_preempt         = 1'b0;
                                n_state           = rmsd_pkg::ST_SQUARE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rmsd_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = rmsd_pkg::ST_ACCUM;
            end
            rmsd_pkg::ST_ACCUM: begin
                o_cmd.accum         = 1'b1;
                o_cmd.div_load_mean = 1'b1;
                n_step              = '0;
                n_state             = rmsd_pkg::ST_DIV_MEAN;
            end
            rmsd_pkg::ST_DIV_MEAN: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == rmsd_pkg::STEP_W'(rmsd_pkg::DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = rmsd_pkg::ST_LOAD_MSQ;
                end
            end
            rmsd_pkg::ST_LOAD_MSQ: begin
                o_cmd.div_load_msq = 1'b1;
                n_state            = rmsd_pkg::ST_DIV_MSQ;
            end
            rmsd_pkg::ST_DIV_MSQ: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == rmsd_pkg::STEP_W'(rmsd_pkg::DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = rmsd_pkg::ST_VAR;
                end
            end
            rmsd_pkg::ST_VAR: begin
                o_cmd.var_load = 1'b1;
                n_state        = rmsd_pkg::ST_SQRT;
            end
            rmsd_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == rmsd_pkg::STEP_W'(rmsd_pkg::SQRT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = rmsd_pkg::ST_RESULT;
                end
            end
            rmsd_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_preempt = r_preempt;
                    n_out_valid       = 1'b1;
                    n_state           = rmsd_pkg::ST_IDLE;
                    if (!r_preempt && i_status.finish) begin
                        n_armed = 1'b0;
                    end
                end
            end
            default: begin
                n_state = rmsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rmsd_dp.sv -----
// datapath: goal register, accumulators, shared divider, square root and output word
module rmsd_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rmsd_pkg::GOAL_W-1:0]           i_cfg_wdata,
    input  logic signed [rmsd_pkg::SAMPLE_W-1:0]  i_sample,
    input  rmsd_pkg::t_dp_cmd                     i_cmd,
    output rmsd_pkg::t_dp_status                  o_status,
    output rmsd_pkg::t_out_word                   o_out_word
);

    localparam int SW = rmsd_pkg::SAMPLE_W;

    logic [rmsd_pkg::GOAL_W-1:0]   r_goal;
    logic [rmsd_pkg::COUNT_W-1:0]  r_count;
    logic [rmsd_pkg::SUM_W-1:0]    r_sum;
    logic [rmsd_pkg::SUMSQ_W-1:0]  r_sumsq;

    logic [SW-1:0]                 r_sample;
    logic [rmsd_pkg::SQ_W-1:0]     r_sq;
    logic [rmsd_pkg::REM_W-1:0]    r_div_rem;
    logic [rmsd_pkg::QUO_W-1:0]    r_div_dq;
    logic [rmsd_pkg::MAG_W-1:0]    r_mag_mean;
    logic                          r_neg;
    logic [rmsd_pkg::SQ_W-1:0]     r_mean_sq;
    rmsd_pkg::t_goal_status        r_status;
    logic [rmsd_pkg::RAD_W-1:0]    r_rad;
    logic [rmsd_pkg::ROOT_W:0]     r_srem;
    logic [rmsd_pkg::ROOT_W-1:0]   r_root;
    rmsd_pkg::t_out_word           r_out;

    logic [rmsd_pkg::MAG_W-1:0]    w_mag_s;
    logic [rmsd_pkg::SUM_W-1:0]    w_neg_sum;
    logic [rmsd_pkg::SUM_W-2:0]    w_mag_sum;
    logic [rmsd_pkg::DIVD_W-1:0]   w_dividend;
    logic [rmsd_pkg::REM_W:0]      w_div_trial;
    logic [rmsd_pkg::REM_W:0]      w_div_sub;
    logic                          w_div_ge;
    logic [rmsd_pkg::QUO_W-1:0]    w_var;
    logic [rmsd_pkg::ROOT_W+2:0]   w_sq_shift;
    logic [rmsd_pkg::ROOT_W+2:0]   w_sq_trial;
    logic [rmsd_pkg::ROOT_W+2:0]   w_sq_diff;
    logic [SW-1:0]                 w_mean;

    // magnitude of the held sample, 0x8000 reads as 32768
    assign w_mag_s   = r_sample[SW-1] ? (-r_sample) : r_sample;
    assign w_neg_sum = -r_sum;
    assign w_mag_sum = r_sum[rmsd_pkg::SUM_W-1] ? w_neg_sum[rmsd_pkg::SUM_W-2:0]
                                                : r_sum[rmsd_pkg::SUM_W-2:0];

    // restoring divider, one quotient bit per step, divisor is the count
    assign w_div_trial = {r_div_rem, r_div_dq[rmsd_pkg::QUO_W-1]};
    assign w_div_ge    = (w_div_trial >= {1'b0, r_count});
    assign w_div_sub   = w_div_trial - {1'b0, r_count};

    assign w_dividend = i_cmd.div_load_msq ? r_sumsq[rmsd_pkg::DIVD_W-1:0]
                                           : rmsd_pkg::DIVD_W'(w_mag_sum);

    assign w_var = (r_div_dq >= r_mean_sq) ? (r_div_dq - r_mean_sq)
                                           : (r_mean_sq - r_div_dq);

    // digit recurrence square root, two radicand bits per step
    assign w_sq_shift = {r_srem, r_rad[rmsd_pkg::RAD_W-1 -: 2]};
    assign w_sq_trial = {1'b0, r_root, 2'b01};
    assign w_sq_diff  = w_sq_shift - w_sq_trial;

    assign w_mean = r_neg ? (-r_mag_mean) : r_mag_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            if (i_cfg_we) begin
                r_goal <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
            end else begin
                if (i_cmd.square) begin
                    if (r_count != {rmsd_pkg::COUNT_W{1'b1}}) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_sum <= r_sum + {{(rmsd_pkg::SUM_W-SW){r_sample[SW-1]}}, r_sample};
                end
                if (i_cmd.accum) begin
                    r_sumsq <= r_sumsq + rmsd_pkg::SUMSQ_W'(r_sq);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_sample <= i_sample;
        end
        if (i_cmd.square) begin
            r_sq <= w_mag_s * w_mag_s;
        end
        if (i_cmd.div_load_mean || i_cmd.div_load_msq) begin
            r_div_rem <= rmsd_pkg::REM_W'(w_dividend[rmsd_pkg::DIVD_W-1:rmsd_pkg::QUO_W]);
            r_div_dq  <= w_dividend[rmsd_pkg::QUO_W-1:0];
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_div_ge ? w_div_sub[rmsd_pkg::REM_W-1:0]
                                  : w_div_trial[rmsd_pkg::REM_W-1:0];
            r_div_dq  <= {r_div_dq[rmsd_pkg::QUO_W-2:0], w_div_ge};
        end
        if (i_cmd.div_load_msq) begin
            r_mag_mean <= r_div_dq[rmsd_pkg::MAG_W-1:0];
            r_neg      <= r_sum[rmsd_pkg::SUM_W-1];
        end
        // mean magnitude holds steady during the second division
        if (i_cmd.div_step) begin
            r_mean_sq <= r_mag_mean * r_mag_mean;
        end
        if (i_cmd.var_load) begin
            r_rad  <= w_var;
            r_srem <= '0;
            r_root <= '0;
            if (r_count > {1'b0, r_goal}) begin
                r_status <= r_neg ? rmsd_pkg::GS_ABORTED : rmsd_pkg::GS_SUCCEEDED;
            end else begin
                r_status <= rmsd_pkg::GS_ACTIVE;
            end
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[rmsd_pkg::RAD_W-3:0], 2'b00};
            if (w_sq_shift >= w_sq_trial) begin
                r_srem <= w_sq_diff[rmsd_pkg::ROOT_W:0];
                r_root <= {r_root[rmsd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= w_sq_shift[rmsd_pkg::ROOT_W:0];
                r_root <= {r_root[rmsd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_preempt) begin
                r_out.status      <= rmsd_pkg::GS_PREEMPTED;
                r_out.sample_echo <= '0;
                r_out.mean        <= '0;
                r_out.std_dev     <= '0;
            end else begin
                r_out.status      <= r_status;
                r_out.sample_echo <= r_sample;
                r_out.mean        <= w_mean;
                r_out.std_dev     <= r_root;
            end
        end
    end

    assign o_status.finish = (r_status != rmsd_pkg::GS_ACTIVE);
    assign o_out_word      = r_out;

endmodule

// ----- hw/rtl/running_mean_std_dev.sv -----
// top level of the running mean and standard deviation engine
//
//  channel  direction  handshake                 word
//  -------  ---------  ------------------------  ---------------------------------------
//  in       input      i_in_valid / o_in_ready    func, sample
//  out      output     o_out_valid / i_out_ready  status, sample_echo, mean, std_dev
//  cfg      input      i_cfg_we                   sample_goal, written with no wait
//
//  a sample taken while armed is squared and accumulated, then run through the shared
//    one-bit-per-cycle divider (two 32-step divisions) and the 16-step square root; the
//    block takes no new word until its result word is loaded into the output register
//  start and ignored words are handled in idle; preempt goes through the result state for its result
//  synchronous active-low reset clears the goal register, the accumulators and the armed flag
//  a result word waiting on i_out_ready does not hold off the next input word; only the
//    next result waits for the output register to free up
module running_mean_std_dev (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rmsd_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rmsd_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [rmsd_pkg::GOAL_W-1:0]         i_cfg_wdata
);

    // command and status between the controller and the datapath
    rmsd_pkg::t_dp_cmd    w_cmd;
    rmsd_pkg::t_dp_status w_status;

    // sequencer: accepts words, tracks the armed goal, steps the datapath
    rmsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in_word.func),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // accumulators, divider, multiplier, square root and the output register
    rmsd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_in_word.sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_word  (o_out_word)
    );

    // a new result is loaded only when the output register is free
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a waiting word");

    // divider and square root never run in the same cycle
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.div_step && w_cmd.sqrt_step))
        else $error("divider and square root stepped together");

    // the input side is closed while a sample is being worked on
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_step || w_cmd.sqrt_step || w_cmd.square) |-> !o_in_ready)
        else $error("input ready while the datapath is busy");

    // a preempted result carries zero fields
    a_preempt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == rmsd_pkg::GS_PREEMPTED)) |->
        ((o_out_word.sample_echo == '0) && (o_out_word.mean == '0) &&
         (o_out_word.std_dev == '0)))
        else $error("preempted word with nonzero fields");

endmodule

// ----- sim/tb_running_mean_std_dev.sv -----
// self-checking testbench for the running mean and standard deviation engine
`timescale 1ns / 100ps

module tb_running_mean_std_dev;

    localparam int          CLK_HALF      = 6;
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;          // func code the block ignores
    localparam longint      COUNT_MAX     = (64'd1 << rmsd_pkg::COUNT_W) - 1;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          LONG_HOLD     = 600;           // receiver back-pressure stretch
    localparam int          HOLD_AFTER    = 100;           // results seen before the long hold
    localparam int          PHASE_WORDS   = 110;           // live words per random phase
    localparam int          NUM_PHASES    = 7;

    // dut ports, inputs known from time zero
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    rmsd_pkg::t_in_word            i_in_word   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    rmsd_pkg::t_out_word           o_out_word;
    logic                          i_cfg_we    = 1'b0;
    logic [rmsd_pkg::GOAL_W-1:0]   i_cfg_wdata = '0;

    // words waiting to be offered and results waiting to be seen
    rmsd_pkg::t_in_word   in_words_q[$];
    rmsd_pkg::t_out_word  stats_due_q[$];
    rmsd_pkg::t_out_word  want;

    int unsigned          words_queued   = 0;
    int unsigned          words_accepted = 0;
    int unsigned          results_seen   = 0;
    int unsigned          errors         = 0;
    int unsigned          send_gap       = 0;
    int unsigned          hold_left      = 0;
    bit                   long_hold_done = 1'b0;
    bit                   idle_on        = 1'b1;

    // predictor state, mirrors the block's accumulators and goal register
    bit                   armed_m = 1'b0;
    longint unsigned      count_m = 0;
    longint               sum_m   = 0;
    longint unsigned      sumsq_m = 0;
    longint unsigned      goal_m  = 0;

    running_mean_std_dev i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // floor of the square root, bit by bit from the top; operands stay below 2^48
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 25; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    // advance the statistics for one accepted word and queue the result it causes
    function automatic void update_stats(rmsd_pkg::t_in_word w);
        logic [1:0]           fn;
        longint               smp;
        longint               mean_v;
        longint unsigned      mag;
        longint unsigned      mag_sum;
        longint unsigned      mag_mean;
        longint unsigned      msq;
        longint unsigned      mean_sq;
        longint unsigned      var_v;
        longint unsigned      sd;
        rmsd_pkg::t_out_word  r;
        fn = w.func;
        if (fn == rmsd_pkg::FUNC_START) begin
            // restart clears everything, armed or not, and gives no result
            count_m = 0;
            sum_m   = 0;
            sumsq_m = 0;
            armed_m = 1'b1;
        end else if (fn == rmsd_pkg::FUNC_PREEMPT) begin
            if (armed_m) begin
                armed_m       = 1'b0;
                r             = '0;
                r.status      = rmsd_pkg::GS_PREEMPTED;
                stats_due_q.push_back(r);
            end
        end else if (fn == rmsd_pkg::FUNC_SAMPLE && armed_m) begin
            smp = longint'(w.sample);
            mag = (smp < 0) ? longint'(-smp) : longint'(smp);
            if (count_m < COUNT_MAX) count_m++;
            sum_m   += smp;
            sumsq_m += mag * mag;
            mag_sum  = (sum_m < 0) ? longint'(-sum_m) : longint'(sum_m);
            mag_mean = mag_sum / count_m;
            mean_v   = (sum_m < 0) ? -longint'(mag_mean) : longint'(mag_mean);
            msq      = sumsq_m / count_m;
            mean_sq  = mag_mean * mag_mean;
            var_v    = (msq >= mean_sq) ? msq - mean_sq : mean_sq - msq;
            sd       = int_sqrt(var_v);
            if (sd > 64'hFFFF) sd = 64'hFFFF;
            r.status = rmsd_pkg::GS_ACTIVE;
            if (count_m > goal_m) begin
                // sign of the exact sum decides, not the truncated mean
                r.status = (sum_m < 0) ? rmsd_pkg::GS_ABORTED : rmsd_pkg::GS_SUCCEEDED;
                armed_m  = 1'b0;
            end
            r.sample_echo = w.sample;
            r.mean        = mean_v[rmsd_pkg::SAMPLE_W-1:0];
            r.std_dev     = sd[rmsd_pkg::ROOT_W-1:0];
            stats_due_q.push_back(r);
        end
    endfunction

    // mostly short gaps, some medium, a few long enough to span a whole sample
    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(0, 3);
        if (pick < 95) return $urandom_range(4, 30);
        return $urandom_range(40, 200);
    endfunction

    // sample values biased toward the extremes and toward small magnitudes
    function automatic logic signed [rmsd_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return rmsd_pkg::SAMPLE_W'($urandom_range(0, 511) - 256);
            default: return rmsd_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_word(logic [1:0] fn, logic signed [rmsd_pkg::SAMPLE_W-1:0] smp);
        in_words_q.push_back(rmsd_pkg::t_in_word'({fn, smp}));
        words_queued++;
    endtask

    // wait until every queued word is taken and every result is seen, then let the block settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (!(words_accepted == words_queued && stats_due_q.size() == 0));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_goal(logic [rmsd_pkg::GOAL_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        goal_m       = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // goal runs with random content, plus some noise and broken runs
    task automatic queue_random_phase(int unsigned goal, int unsigned target);
        int unsigned live;
        int unsigned len;
        int unsigned pick;
        live = 0;
        while (live < target) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // noise: any func code, any value
                push_word(2'($urandom_range(0, 3)), pick_sample());
            end else begin
                push_word(rmsd_pkg::FUNC_START, rmsd_pkg::SAMPLE_W'($urandom_range(0, 65535)));
                live++;
                len = (goal < 40) ? goal + 1 : $urandom_range(1, 40);
                // cut the run short and preempt it
                if (pick == 1 && len > 1) len = $urandom_range(1, len - 1);
                for (int k = 0; k < len; k++) push_word(rmsd_pkg::FUNC_SAMPLE, pick_sample());
                live += len;
                if (pick == 1) begin
                    push_word(rmsd_pkg::FUNC_PREEMPT, pick_sample());
                    live++;
                end
                // stray samples after the goal is over are dropped
                if (pick == 2) begin
                    for (int k = 0; k < $urandom_range(1, 3); k++)
                        push_word(rmsd_pkg::FUNC_SAMPLE, pick_sample());
                end
            end
        end
    endtask

    // driver: offers queued words, holds each one until taken, random gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                update_stats(i_in_word);
                words_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (in_words_q.size() > 0) begin
                    i_in_word  <= in_words_q.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap    = idle_on ? gap_len() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction, drives back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (stats_due_q.size() == 0) begin
                    $display("%0t: result with no expected word, expected none, actual %h",
                             $time, o_out_word);
                    errors++;
                end else begin
                    want = stats_due_q.pop_front();
                    if (o_out_word.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, o_out_word.status);
                        errors++;
                    end
                    if (o_out_word.sample_echo !== want.sample_echo) begin
                        $display("%0t: sample_echo mismatch, expected %0d, actual %0d",
                                 $time, want.sample_echo, o_out_word.sample_echo);
                        errors++;
                    end
                    if (o_out_word.mean !== want.mean) begin
                        $display("%0t: mean mismatch, expected %0d, actual %0d",
                                 $time, want.mean, o_out_word.mean);
                        errors++;
                    end
                    if (o_out_word.std_dev !== want.std_dev) begin
                        $display("%0t: std_dev mismatch, expected %0d, actual %0d",
                                 $time, want.std_dev, o_out_word.std_dev);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                // one long hold so the output register backs up into the input side
                if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                    long_hold_done = 1'b1;
                    hold_left      = LONG_HOLD;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    hold_left = gap_len();
                end
                i_out_ready <= (hold_left == 0);
            end
        end
    end

    // stimulus sequencer: directed runs first, then random phases over several goals
    initial begin
        int unsigned goals [NUM_PHASES];
        goals = '{1, 0, 3, 8, 65535, 15, 2};
        goals[5] = $urandom_range(2, 24);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // goal still at its reset value of zero
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh7fff);      // disarmed, dropped
        push_word(rmsd_pkg::FUNC_PREEMPT, 16'sh0000);     // disarmed, dropped
        push_word(FUNC_UNUSED, 16'sh1234);                // unused code, dropped
        push_word(rmsd_pkg::FUNC_START, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh8000);      // first sample ends the goal, aborted
        wait_idle();

        write_goal(16'd4);
        // alternating extremes give the widest spread
        push_word(rmsd_pkg::FUNC_START, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh7fff);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh8000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh7fff);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh8000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh7fff);
        // restart while armed, then a tiny negative sum that truncates to a zero mean
        push_word(rmsd_pkg::FUNC_START, 16'sh0000);
        push_word(rmsd_pkg::FUNC_START, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, -16'sd1);
        // unused code while armed, preempt, then preempt and sample while disarmed
        push_word(rmsd_pkg::FUNC_START, 16'sh0000);
        push_word(FUNC_UNUSED, 16'sh7fff);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sd100);
        push_word(rmsd_pkg::FUNC_PREEMPT, 16'sh0000);
        push_word(rmsd_pkg::FUNC_PREEMPT, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sd5);
        wait_idle();

        write_goal(16'hffff);
        push_word(rmsd_pkg::FUNC_START, 16'sh0000);
        push_word(rmsd_pkg::FUNC_SAMPLE, 16'sh8000);
        push_word(rmsd_pkg::FUNC_PREEMPT, 16'sh0000);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_on = (p != 2);                 // one phase runs flat out on both sides
            write_goal(goals[p]);
            queue_random_phase(goals[p], PHASE_WORDS);
            wait_idle();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit, far past the slowest legal run
    initial begin
        #(64'd16_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
